### src/one_wire_bus_master_defines.svh
// assertion macros for the one-wire bus master checker
// expects clk and rst_n to be visible where the macros are used
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define OWBM_ASSERT_SAME(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("one-wire master check failed");

// consequent must hold in the cycle after the antecedent
`define OWBM_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("one-wire master check failed");

`endif

### src/owbm_pkg.sv
// shared constants for the one-wire bus master: register map, command
// and status codes, stream field positions; no dependencies
package owbm_pkg;

    localparam int TICK_COUNT_BITS_DEF = 10;

    localparam int CFG_W   = 10;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef logic [2:0]       reg_idx_t;

    // register indexes (byte address is 4 * index)
    localparam reg_idx_t REG_RESET_LOW     = 3'd0;
    localparam reg_idx_t REG_RESET_RELEASE = 3'd1;
    localparam reg_idx_t REG_PRES_TIMEOUT  = 3'd2;
    localparam reg_idx_t REG_SLOT_START    = 3'd3;
    localparam reg_idx_t REG_WRITE_HOLD    = 3'd4;
    localparam reg_idx_t REG_READ_DELAY    = 3'd5;
    localparam reg_idx_t REG_READ_HOLD     = 3'd6;
    localparam reg_idx_t REG_RECOVERY      = 3'd7;

    localparam cfg_word_t RST_RESET_LOW     = 10'd750;
    localparam cfg_word_t RST_RESET_RELEASE = 10'd15;
    localparam cfg_word_t RST_PRES_TIMEOUT  = 10'd240;
    localparam cfg_word_t RST_SLOT_START    = 10'd2;
    localparam cfg_word_t RST_WRITE_HOLD    = 10'd60;
    localparam cfg_word_t RST_READ_DELAY    = 10'd10;
    localparam cfg_word_t RST_READ_HOLD     = 10'd60;
    localparam cfg_word_t RST_RECOVERY      = 10'd2;

    // command codes
    localparam logic [1:0] FUNC_RESET = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // presence status codes
    localparam logic [1:0] STAT_PRESENT      = 2'd0;
    localparam logic [1:0] STAT_NO_PULSE     = 2'd1;
    localparam logic [1:0] STAT_NOT_RELEASED = 2'd2;

    // stream field positions
    localparam int IN_TDATA_W    = 16;
    localparam int IN_TUSER_W    = 3;
    localparam int OUT_TDATA_W   = 16;
    localparam int IN_WDATA_LSB  = 0;
    localparam int IN_LINE_BIT   = 8;
    localparam int USER_START    = 0;
    localparam int USER_FUNC_LSB = 1;
    localparam int OUT_DRIVE_BIT = 0;
    localparam int OUT_BUSY_BIT  = 1;
    localparam int OUT_DONE_BIT  = 2;
    localparam int OUT_RDATA_LSB = 3;
    localparam int OUT_STAT_LSB  = 11;

endpackage

### src/one_wire_bus_master.sv
// one-wire bus master: reset/presence, write byte, read byte, one tick per request
// depends on owbm_pkg
//
//  channel   | direction | request contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one microsecond tick: command, data byte, line level
//  m_axis    | out       | line drive, busy, done, read byte, presence status
//  apb       | in/out    | eight 10-bit timing registers at 4-byte spacing
//
// one request per clock sustained while results are taken; a tick is held in the input register,
// is evaluated in a single pass and is registered into the result register when it fires.
// zero-length phases are skipped within the same tick.
// rst_n clears the command state, the read byte and the status and loads the
// timing registers with their defaults; no clearing pass.
// a stalled result holds the input register; s_axis_tready drops only then.
module one_wire_bus_master #(
    parameter int TICK_COUNT_BITS = owbm_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0]     paddr,
    input  logic [owbm_pkg::DATA_W-1:0]     pwdata,
    output logic [owbm_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // write_data[7:0], line_in[8], zero[15:9]
    input  logic [owbm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // start_req[0], func[2:1]
    input  logic [owbm_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // drive_low[0], busy_res[1], done_res[2], read_data[10:3],
    // presence_status[12:11], zero[15:13]
    output logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW = TICK_COUNT_BITS;
    localparam int LW = (CW > owbm_pkg::CFG_W) ? CW : owbm_pkg::CFG_W;
    localparam logic [LW-1:0] CNT_MAX = LW'((64'd1 << CW) - 64'd1);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_REL   = 4'd2;
    localparam logic [3:0] PH_PRES_LOW  = 4'd3;
    localparam logic [3:0] PH_PRES_HIGH = 4'd4;
    localparam logic [3:0] PH_W_START   = 4'd5;
    localparam logic [3:0] PH_W_HOLD    = 4'd6;
    localparam logic [3:0] PH_W_REC     = 4'd7;
    localparam logic [3:0] PH_R_START   = 4'd8;
    localparam logic [3:0] PH_R_DELAY   = 4'd9;
    localparam logic [3:0] PH_R_HOLD    = 4'd10;

    // position inside a time slot
    localparam logic [1:0] POS_OPEN   = 2'd0;
    localparam logic [1:0] POS_SAMPLE = 2'd1;
    localparam logic [1:0] POS_END    = 2'd2;

    function automatic logic [CW-1:0] sat_len(input owbm_pkg::cfg_word_t v);
        logic [LW-1:0] ext;
        ext = LW'(v);
        if (ext > CNT_MAX)
            sat_len = CNT_MAX[CW-1:0];
        else
            sat_len = ext[CW-1:0];
    endfunction

    // timing registers
    owbm_pkg::cfg_word_t rst_low_reg, rst_rel_reg, pres_tmo_reg, slot_start_reg;
    owbm_pkg::cfg_word_t wr_hold_reg, rd_delay_reg, rd_hold_reg, recovery_reg;

    logic                cfg_we;
    owbm_pkg::reg_idx_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_low_reg    <= owbm_pkg::RST_RESET_LOW;
            rst_rel_reg    <= owbm_pkg::RST_RESET_RELEASE;
            pres_tmo_reg   <= owbm_pkg::RST_PRES_TIMEOUT;
            slot_start_reg <= owbm_pkg::RST_SLOT_START;
            wr_hold_reg    <= owbm_pkg::RST_WRITE_HOLD;
            rd_delay_reg   <= owbm_pkg::RST_READ_DELAY;
            rd_hold_reg    <= owbm_pkg::RST_READ_HOLD;
            recovery_reg   <= owbm_pkg::RST_RECOVERY;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                owbm_pkg::REG_RESET_LOW:     rst_low_reg    <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_RESET_RELEASE: rst_rel_reg    <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_PRES_TIMEOUT:  pres_tmo_reg   <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_SLOT_START:    slot_start_reg <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_WRITE_HOLD:    wr_hold_reg    <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_READ_DELAY:    rd_delay_reg   <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_READ_HOLD:     rd_hold_reg    <= pwdata[owbm_pkg::CFG_W-1:0];
                owbm_pkg::REG_RECOVERY:      recovery_reg   <= pwdata[owbm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            owbm_pkg::REG_RESET_LOW:     prdata = owbm_pkg::DATA_W'(rst_low_reg);
            owbm_pkg::REG_RESET_RELEASE: prdata = owbm_pkg::DATA_W'(rst_rel_reg);
            owbm_pkg::REG_PRES_TIMEOUT:  prdata = owbm_pkg::DATA_W'(pres_tmo_reg);
            owbm_pkg::REG_SLOT_START:    prdata = owbm_pkg::DATA_W'(slot_start_reg);
            owbm_pkg::REG_WRITE_HOLD:    prdata = owbm_pkg::DATA_W'(wr_hold_reg);
            owbm_pkg::REG_READ_DELAY:    prdata = owbm_pkg::DATA_W'(rd_delay_reg);
            owbm_pkg::REG_READ_HOLD:     prdata = owbm_pkg::DATA_W'(rd_hold_reg);
            owbm_pkg::REG_RECOVERY:      prdata = owbm_pkg::DATA_W'(recovery_reg);
            default:                     prdata = '0;
        endcase
    end

    // saturated phase lengths
    logic [CW-1:0] len_rst_low, len_rst_rel, len_tmo, len_slot;
    logic [CW-1:0] len_wr_hold, len_rd_delay, len_rd_hold, len_recovery;

    assign len_rst_low  = sat_len(rst_low_reg);
    assign len_rst_rel  = sat_len(rst_rel_reg);
    assign len_tmo      = sat_len(pres_tmo_reg);
    assign len_slot     = sat_len(slot_start_reg);
    assign len_wr_hold  = sat_len(wr_hold_reg);
    assign len_rd_delay = sat_len(rd_delay_reg);
    assign len_rd_hold  = sat_len(rd_hold_reg);
    assign len_recovery = sat_len(recovery_reg);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_start_reg;
    logic [1:0] in_func_reg;
    logic [7:0] in_wdata_reg;
    logic       in_line_reg;

    // result register
    logic out_valid_reg, out_valid_next;
    logic out_drive_reg, out_busy_reg, out_done_reg;

    // command state
    logic [3:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    rdata_reg, rdata_next;
    logic          drive_next, busy_next, done_next;

    logic out_free, s_fire, fire;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_fire)
            in_valid_next = 1'b1;
        else if (out_free)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (out_free)
            out_valid_next = in_valid_reg;
        else
            out_valid_next = out_valid_reg;
    end

    // one tick of the bus sequencer
    always_comb
    begin
        logic [3:0]    ph;
        logic [CW-1:0] cnt;
        logic [2:0]    bi;
        logic [7:0]    sh;
        logic [1:0]    st;
        logic [7:0]    rd;
        logic          drv, busy, done;
        logic [CW-1:0] len;
        logic          timed;
        logic          is_rd;
        logic [2:0]    zf;
        logic [1:0]    pos;
        logic          stopped, ended;
        logic          want;

        ph      = phase_reg;
        cnt     = cnt_reg;
        bi      = bit_reg;
        sh      = shift_reg;
        st      = status_reg;
        rd      = rdata_reg;
        drv     = 1'b0;
        busy    = 1'b0;
        done    = 1'b0;
        len     = '0;
        timed   = 1'b0;
        is_rd   = 1'b0;
        zf      = '0;
        pos     = POS_OPEN;
        stopped = 1'b0;
        ended   = 1'b0;
        want    = 1'b0;

        if (ph == PH_IDLE && in_start_reg)
        begin
            case (in_func_reg)
                owbm_pkg::FUNC_RESET:
                begin
                    ph  = PH_RST_LOW;
                    cnt = '0;
                    bi  = '0;
                end
                owbm_pkg::FUNC_WRITE:
                begin
                    ph  = PH_W_START;
                    cnt = '0;
                    bi  = '0;
                    sh  = in_wdata_reg;
                end
                owbm_pkg::FUNC_READ:
                begin
                    ph  = PH_R_START;
                    cnt = '0;
                    bi  = '0;
                    sh  = '0;
                end
                default: ;
            endcase
        end

        if (ph != PH_IDLE)
        begin
            case (ph)
                PH_RST_LOW:  begin len = len_rst_low;  timed = 1'b1; end
                PH_RST_REL:  begin len = len_rst_rel;  timed = 1'b1; end
                PH_W_START:  begin len = len_slot;     timed = 1'b1; end
                PH_W_HOLD:   begin len = len_wr_hold;  timed = 1'b1; end
                PH_W_REC:    begin len = len_recovery; timed = 1'b1; end
                PH_R_START:  begin len = len_slot;     timed = 1'b1; end
                PH_R_DELAY:  begin len = len_rd_delay; timed = 1'b1; end
                PH_R_HOLD:   begin len = len_rd_hold;  timed = 1'b1; end
                default:     timed = 1'b0;
            endcase

            // phase expired: walk forward past zero-length phases
            if (timed && cnt >= len)
            begin
                cnt = '0;
                case (ph)
                    PH_RST_LOW:
                        ph = (len_rst_rel == '0) ? PH_PRES_LOW : PH_RST_REL;
                    PH_RST_REL:
                        ph = PH_PRES_LOW;
                    PH_W_START, PH_W_HOLD, PH_W_REC, PH_R_START, PH_R_DELAY, PH_R_HOLD:
                    begin
                        is_rd = (ph == PH_R_START) || (ph == PH_R_DELAY) || (ph == PH_R_HOLD);
                        if (is_rd)
                        begin
                            zf  = {len_rd_hold == '0, len_rd_delay == '0, len_slot == '0};
                            pos = 2'(ph - PH_R_START);
                        end
                        else
                        begin
                            zf  = {len_recovery == '0, len_wr_hold == '0, len_slot == '0};
                            pos = 2'(ph - PH_W_START);
                        end
                        for (int k = 0; k < 6; k++)
                        begin
                            if (!stopped && !ended)
                            begin
                                if (is_rd && pos == POS_SAMPLE)
                                    sh = {in_line_reg, sh[7:1]};
                                if (pos == POS_END)
                                begin
                                    if (!is_rd)
                                        sh = {1'b0, sh[7:1]};
                                    if (&bi)
                                    begin
                                        ended = 1'b1;
                                        if (is_rd)
                                            rd = sh;
                                    end
                                    else
                                    begin
                                        bi  = bi + 3'd1;
                                        pos = POS_OPEN;
                                    end
                                end
                                else
                                    pos = pos + 2'd1;
                                if (!ended && !zf[pos])
                                    stopped = 1'b1;
                            end
                        end
                        if (ended)
                            ph = PH_IDLE;
                        else if (!stopped)
                        begin
                            // every slot length zero: the whole byte runs on this tick
                            ph = PH_IDLE;
                            if (is_rd)
                                rd = {8{in_line_reg}};
                        end
                        else if (is_rd)
                            ph = PH_R_START + 4'(pos);
                        else
                            ph = PH_W_START + 4'(pos);
                    end
                    default: ;
                endcase
            end

            if (ph == PH_IDLE)
                done = 1'b1;
            else
            begin
                busy = 1'b1;
                if (ph == PH_PRES_LOW || ph == PH_PRES_HIGH)
                begin
                    want = (ph == PH_PRES_LOW) ? !in_line_reg : in_line_reg;
                    if (want)
                    begin
                        if (ph == PH_PRES_LOW)
                        begin
                            ph  = PH_PRES_HIGH;
                            cnt = '0;
                        end
                        else
                        begin
                            st   = owbm_pkg::STAT_PRESENT;
                            ph   = PH_IDLE;
                            cnt  = '0;
                            busy = 1'b0;
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt = cnt + 1'b1;
                        if (cnt >= len_tmo || cnt == '0)
                        begin
                            st   = (ph == PH_PRES_LOW) ? owbm_pkg::STAT_NO_PULSE
                                                       : owbm_pkg::STAT_NOT_RELEASED;
                            ph   = PH_IDLE;
                            cnt  = '0;
                            busy = 1'b0;
                            done = 1'b1;
                        end
                    end
                end
                else
                begin
                    case (ph)
                        PH_RST_LOW, PH_W_START, PH_R_START: drv = 1'b1;
                        PH_W_HOLD:                          drv = !sh[0];
                        default:                            drv = 1'b0;
                    endcase
                    cnt = cnt + 1'b1;
                end
            end
        end

        phase_next  = ph;
        cnt_next    = cnt;
        bit_next    = bi;
        shift_next  = sh;
        status_next = st;
        rdata_next  = rd;
        drive_next  = drv;
        busy_next   = busy;
        done_next   = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            status_reg    <= owbm_pkg::STAT_PRESENT;
            rdata_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                status_reg <= status_next;
                rdata_reg  <= rdata_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_start_reg <= s_axis_tuser[owbm_pkg::USER_START];
            in_func_reg  <= s_axis_tuser[owbm_pkg::USER_FUNC_LSB +: 2];
            in_wdata_reg <= s_axis_tdata[owbm_pkg::IN_WDATA_LSB +: 8];
            in_line_reg  <= s_axis_tdata[owbm_pkg::IN_LINE_BIT];
        end
        if (fire)
        begin
            out_drive_reg <= drive_next;
            out_busy_reg  <= busy_next;
            out_done_reg  <= done_next;
        end
    end

    // read byte and status come straight from state: it only moves with a new result
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, status_reg, rdata_reg,
                            out_done_reg, out_busy_reg, out_drive_reg};

endmodule

### src/owbm_checker.sv
// port-level checks for the one-wire bus master, bound to the top level
// depends on owbm_pkg and one_wire_bus_master_defines.svh
`include "one_wire_bus_master_defines.svh"

module owbm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       m_fire, done, busy, drive;
    logic [7:0] rdata;
    logic [1:0] stat;
    logic [7:0] last_rdata_reg;
    logic [1:0] last_stat_reg;

    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign done   = m_axis_tdata[owbm_pkg::OUT_DONE_BIT];
    assign busy   = m_axis_tdata[owbm_pkg::OUT_BUSY_BIT];
    assign drive  = m_axis_tdata[owbm_pkg::OUT_DRIVE_BIT];
    assign rdata  = m_axis_tdata[owbm_pkg::OUT_RDATA_LSB +: 8];
    assign stat   = m_axis_tdata[owbm_pkg::OUT_STAT_LSB +: 2];

    // read byte and status seen on the last taken result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rdata_reg <= '0;
            last_stat_reg  <= owbm_pkg::STAT_PRESENT;
        end
        else if (m_fire)
        begin
            last_rdata_reg <= rdata;
            last_stat_reg  <= stat;
        end
    end

    `OWBM_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata))
    `OWBM_ASSERT_SAME(a_stall_from_output, !s_axis_tready,
                      m_axis_tvalid && !m_axis_tready)
    `OWBM_ASSERT_SAME(a_sticky_fields, m_fire && !done,
                      rdata == last_rdata_reg && stat == last_stat_reg)
    `OWBM_ASSERT_SAME(a_done_releases, m_axis_tvalid && done,
                      !busy && !drive && stat != 2'b11)

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);

### bench/tb.sv
// testbench for one_wire_bus_master: random ticks and command sequences are streamed in,
// every result is checked against a cycle-true prediction of the bus master
// depends on owbm_pkg and the one_wire_bus_master rtl
`timescale 1ns / 1ps

module tb;
    import owbm_pkg::*;

    localparam int        IDLE_PCT        = 32;
    localparam int        CYCLE_LIMIT     = 400000;
    localparam int        SETTLE_CYCLES   = 8;
    localparam int        STALL_CYCLES    = 300;
    localparam int        NUM_TIMING_REGS = 8;
    localparam int        BITS_PER_BYTE   = 8;
    localparam int        PHASE_TICKS     = 90;
    localparam int        LONG_SPAN       = 100;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam cfg_word_t TIMING_MAX      = '1;

    typedef struct packed {
        logic       start;
        logic [1:0] func;
        logic [7:0] wdata;
        logic       line;
    } bus_tick_t;

    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic [1:0] status;
    } line_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RST_LOW,
        ST_RST_REL,
        ST_PRES_LOW,
        ST_PRES_HIGH,
        ST_W_START,
        ST_W_HOLD,
        ST_W_REC,
        ST_R_START,
        ST_R_DELAY,
        ST_R_HOLD
    } bus_state_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // write_data[7:0], line_in[8], zero[15:9]
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // start_req[0], func[2:1]
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // drive_low[0], busy_res[1], done_res[2], read_data[10:3], presence_status[12:11]
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // predicted master state and its copy of the timing registers
    bus_state_t                     bus_state = ST_IDLE;
    logic [TICK_COUNT_BITS_DEF-1:0] slot_timer = '0;
    logic [2:0]                     slot_bit = '0;
    logic [7:0]                     shifter = '0;
    logic [1:0]                     presence_q = STAT_PRESENT;
    logic [7:0]                     read_byte_q = '0;
    cfg_word_t                      bus_timing [NUM_TIMING_REGS];

    bus_tick_t    pending_ticks [$];
    line_result_t predicted_outputs [$];

    int error_count = 0;
    int cycle_count = 0;
    int queued_ticks = 0;
    int stall_asked = 0;
    int stall_taken = 0;
    int stall_left = 0;
    bit no_gaps = 1'b0;
    bit busy_pokes = 1'b1;

    one_wire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void goto_state(bus_state_t s);
        bus_state = s;
        slot_timer = '0;
    endfunction

    function automatic void finish_slot(bus_state_t restart);
        if (slot_bit == 3'd7)
        begin
            if (restart == ST_R_START)
                read_byte_q = shifter;
            goto_state(ST_IDLE);
        end
        else
        begin
            slot_bit = slot_bit + 3'd1;
            goto_state(restart);
        end
    endfunction

    // one microsecond of the bus master
    function automatic line_result_t master_tick(bus_tick_t t);
        line_result_t r;
        cfg_word_t    len;
        logic         timed;
        logic         hunting;
        logic         want;
        r = '0;
        len = '0;
        if (bus_state == ST_IDLE && t.start && t.func <= FUNC_READ)
        begin
            slot_bit = '0;
            case (t.func)
                FUNC_RESET: goto_state(ST_RST_LOW);
                FUNC_WRITE:
                begin
                    shifter = t.wdata;
                    goto_state(ST_W_START);
                end
                default:
                begin
                    shifter = '0;
                    goto_state(ST_R_START);
                end
            endcase
        end
        if (bus_state != ST_IDLE)
        begin
            // expired timed phases fall through within the same tick
            hunting = 1'b1;
            while (hunting && bus_state != ST_IDLE)
            begin
                timed = 1'b1;
                case (bus_state)
                    ST_RST_LOW:             len = bus_timing[REG_RESET_LOW];
                    ST_RST_REL:             len = bus_timing[REG_RESET_RELEASE];
                    ST_W_START, ST_R_START: len = bus_timing[REG_SLOT_START];
                    ST_W_HOLD:              len = bus_timing[REG_WRITE_HOLD];
                    ST_W_REC:               len = bus_timing[REG_RECOVERY];
                    ST_R_DELAY:             len = bus_timing[REG_READ_DELAY];
                    ST_R_HOLD:              len = bus_timing[REG_READ_HOLD];
                    default:                timed = 1'b0;
                endcase
                if (!timed || slot_timer < len)
                    hunting = 1'b0;
                else
                begin
                    case (bus_state)
                        ST_RST_LOW: goto_state(ST_RST_REL);
                        ST_RST_REL: goto_state(ST_PRES_LOW);
                        ST_W_START: goto_state(ST_W_HOLD);
                        ST_W_HOLD:  goto_state(ST_W_REC);
                        ST_W_REC:
                        begin
                            shifter = shifter >> 1;
                            finish_slot(ST_W_START);
                        end
                        ST_R_START: goto_state(ST_R_DELAY);
                        ST_R_DELAY:
                        begin
                            shifter = {t.line, shifter[7:1]};
                            goto_state(ST_R_HOLD);
                        end
                        ST_R_HOLD:  finish_slot(ST_R_START);
                        default:    goto_state(ST_IDLE);
                    endcase
                end
            end
            if (bus_state == ST_IDLE)
                r.done = 1'b1;
            else if (bus_state == ST_PRES_LOW || bus_state == ST_PRES_HIGH)
            begin
                r.busy = 1'b1;
                want = (bus_state == ST_PRES_LOW) ? !t.line : t.line;
                if (want)
                begin
                    if (bus_state == ST_PRES_LOW)
                        goto_state(ST_PRES_HIGH);
                    else
                    begin
                        presence_q = STAT_PRESENT;
                        goto_state(ST_IDLE);
                        r.busy = 1'b0;
                        r.done = 1'b1;
                    end
                end
                else
                begin
                    slot_timer = slot_timer + 1'b1;
                    // a zero timeout behaves as a single tick
                    if (slot_timer >= bus_timing[REG_PRES_TIMEOUT] || slot_timer == '0)
                    begin
                        presence_q = (bus_state == ST_PRES_LOW) ? STAT_NO_PULSE
                                                                : STAT_NOT_RELEASED;
                        goto_state(ST_IDLE);
                        r.busy = 1'b0;
                        r.done = 1'b1;
                    end
                end
            end
            else
            begin
                r.busy = 1'b1;
                case (bus_state)
                    ST_RST_LOW, ST_W_START, ST_R_START: r.drive = 1'b1;
                    ST_W_HOLD:                          r.drive = !shifter[0];
                    default:                            r.drive = 1'b0;
                endcase
                slot_timer = slot_timer + 1'b1;
            end
        end
        r.rdata = read_byte_q;
        r.status = presence_q;
        return r;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            error_count++;
        end
    endfunction

    // sender: offers the queued requests, predicts each one as it is taken
    always @(posedge clk)
    begin : feed
        bus_tick_t             nxt;
        logic                  offer;
        logic [IN_TDATA_W-1:0] word;
        logic [IN_TUSER_W-1:0] flags;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_outputs.push_back(master_tick(pending_ticks.pop_front()));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                offer = pending_ticks.size() != 0
                        && (no_gaps || $urandom_range(99) >= IDLE_PCT);
                s_axis_tvalid <= offer;
                if (offer)
                begin
                    nxt = pending_ticks[0];
                    word = '0;
                    word[IN_WDATA_LSB +: 8] = nxt.wdata;
                    word[IN_LINE_BIT] = nxt.line;
                    flags = '0;
                    flags[USER_START] = nxt.start;
                    flags[USER_FUNC_LSB +: 2] = nxt.func;
                    s_axis_tdata <= word;
                    s_axis_tuser <= flags;
                end
            end
        end
    end

    // receiver: random back-pressure plus an occasional long hold-off
    always @(posedge clk)
    begin : drain_side
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_asked != stall_taken)
        begin
            stall_taken <= stall_taken + 1;
            stall_left <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
    end

    always @(posedge clk)
    begin : compare
        line_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %0h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                check_field("drive_low", 32'(want.drive), 32'(m_axis_tdata[OUT_DRIVE_BIT]));
                check_field("busy", 32'(want.busy), 32'(m_axis_tdata[OUT_BUSY_BIT]));
                check_field("done", 32'(want.done), 32'(m_axis_tdata[OUT_DONE_BIT]));
                check_field("read_data", 32'(want.rdata),
                            32'(m_axis_tdata[OUT_RDATA_LSB +: 8]));
                check_field("presence", 32'(want.status),
                            32'(m_axis_tdata[OUT_STAT_LSB +: 2]));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_tick(input logic start, input logic [1:0] code,
                             input logic [7:0] data, input logic level);
        bus_tick_t t;
        t.start = start;
        t.func = code;
        t.wdata = data;
        t.line = level;
        pending_ticks.push_back(t);
        queued_ticks++;
    endtask

    // plain ticks inside a command, with the odd request while busy; level < 0 is random
    task automatic push_body(input int n, input int level);
        repeat (n)
            push_tick(busy_pokes && $urandom_range(15) == 0, 2'($urandom_range(3)),
                      8'($urandom_range(255)),
                      1'((level < 0) ? $urandom_range(1) : level));
    endtask

    // writes every timing register, at its floor plus up to span, or at the maximum
    task automatic program_timing(input int span, input bit to_max);
        cfg_word_t v;
        reg_idx_t  idx;
        for (int i = 0; i < NUM_TIMING_REGS; i++)
        begin
            idx = reg_idx_t'(i);
            v = (idx == REG_RESET_LOW || idx == REG_RESET_RELEASE || idx == REG_RECOVERY)
                ? cfg_word_t'(0) : cfg_word_t'(1);
            v = to_max ? TIMING_MAX : v + cfg_word_t'($urandom_range(span));
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= {{(DATA_W - CFG_W){1'b0}}, v};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            bus_timing[idx] = v;
        end
    endtask

    // a start request followed by roughly the ticks the command needs
    task automatic queue_command(input logic [1:0] code);
        int         tmo;
        int         kind;
        logic [7:0] data;
        tmo = int'(bus_timing[REG_PRES_TIMEOUT]);
        case ($urandom_range(3))
            0:       data = 8'h00;
            1:       data = 8'hFF;
            default: data = 8'($urandom_range(255));
        endcase
        push_tick(1'b1, code, data, 1'($urandom_range(1)));
        case (code)
            FUNC_RESET:
            begin
                push_body(int'(bus_timing[REG_RESET_LOW])
                          + int'(bus_timing[REG_RESET_RELEASE]), -1);
                kind = $urandom_range(99);
                if (kind < 15)
                    push_body(tmo + 1, 1);          // nobody answers
                else if (kind < 30)
                    push_body(2 * tmo + 2, 0);      // line held low
                else
                begin
                    push_body($urandom_range(tmo), 1);
                    push_body($urandom_range(tmo + 1, 1), 0);
                    push_body(2, 1);
                end
            end
            FUNC_WRITE:
                push_body(BITS_PER_BYTE * (int'(bus_timing[REG_SLOT_START])
                          + int'(bus_timing[REG_WRITE_HOLD])
                          + int'(bus_timing[REG_RECOVERY])), -1);
            default:
                push_body(BITS_PER_BYTE * (int'(bus_timing[REG_SLOT_START])
                          + int'(bus_timing[REG_READ_DELAY])
                          + int'(bus_timing[REG_READ_HOLD])) + 1, -1);
        endcase
    endtask

    task automatic add_traffic(input int goal);
        int target;
        target = queued_ticks + goal;
        while (queued_ticks < target)
        begin
            if ($urandom_range(99) < 80)
                queue_command(2'($urandom_range(FUNC_READ, FUNC_RESET)));
            else
                repeat ($urandom_range(4, 1))
                    push_tick(1'($urandom_range(1)), 2'($urandom_range(3)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // waits until every request is answered and the master has gone idle
    task automatic settle();
        bit busy_left;
        busy_left = 1'b1;
        while (busy_left)
        begin
            while (pending_ticks.size() != 0 || predicted_outputs.size() != 0)
                @(posedge clk);
            busy_left = (bus_state != ST_IDLE);
            if (busy_left)
                for (int k = 0; k < 32; k++)
                    push_tick(1'b0, FUNC_RESET, 8'h00, k[0]);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : run
        bus_timing[REG_RESET_LOW]     = RST_RESET_LOW;
        bus_timing[REG_RESET_RELEASE] = RST_RESET_RELEASE;
        bus_timing[REG_PRES_TIMEOUT]  = RST_PRES_TIMEOUT;
        bus_timing[REG_SLOT_START]    = RST_SLOT_START;
        bus_timing[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
        bus_timing[REG_READ_DELAY]    = RST_READ_DELAY;
        bus_timing[REG_READ_HOLD]     = RST_READ_HOLD;
        bus_timing[REG_RECOVERY]      = RST_RECOVERY;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // shortest timings: every phase is zero or one tick long
        program_timing(0, 1'b0);
        push_tick(1'b0, FUNC_RESET, 8'h00, 1'b1);
        push_tick(1'b1, FUNC_UNUSED, 8'hFF, 1'b1);
        push_tick(1'b1, FUNC_RESET, 8'h00, 1'b0);   // device answers at once
        push_tick(1'b1, FUNC_WRITE, 8'h5A, 1'b1);   // request on the finishing tick
        push_tick(1'b1, FUNC_RESET, 8'hFF, 1'b1);   // no presence pulse
        push_tick(1'b1, FUNC_RESET, 8'h00, 1'b0);
        push_tick(1'b0, FUNC_RESET, 8'h00, 1'b0);   // line never released
        push_tick(1'b1, FUNC_WRITE, 8'h00, 1'b0);
        push_body(2 * BITS_PER_BYTE, 0);
        push_tick(1'b1, FUNC_READ, 8'hFF, 1'b1);
        push_body(3 * BITS_PER_BYTE, 1);
        settle();

        for (int i = 0; i < 5; i++)
        begin
            program_timing(1 + i, 1'b0);
            if (i == 1)
                stall_asked <= stall_asked + 1;
            add_traffic(PHASE_TICKS);
            settle();
        end

        // long timings, one reset, streamed without any gaps
        program_timing(LONG_SPAN, 1'b0);
        no_gaps = 1'b1;
        busy_pokes = 1'b0;
        queue_command(FUNC_RESET);
        settle();
        no_gaps = 1'b0;

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
